>>> sv/relay_driver_with_feedback_check_top_assert.svh
// ---------------------------------------------------------------------------
// Relay driver assertion macros
// Shared assertion forms used by the relay driver checker.
// ---------------------------------------------------------------------------
`ifndef RELAY_DRIVER_WITH_FEEDBACK_CHECK_TOP_ASSERT_SVH
`define RELAY_DRIVER_WITH_FEEDBACK_CHECK_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RDFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define RDFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define RDFC_ASSERT_RST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/rdfc_pkg.sv
// ---------------------------------------------------------------------------
// Relay driver package
// Types, codes and constants shared by the relay driver modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdfc_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int FORCED_CHECK_MS   = 1000;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic        RST_BISTABLE     = 1'b0;
    localparam logic [15:0] RST_PULSE_LEN    = 16'd50;
    localparam logic [15:0] RST_CHECK_PERIOD = 16'd5000;
    localparam logic [7:0]  RST_RETRY_LIMIT  = 8'd3;

    typedef enum logic [1:0] {
        OP_POLL       = 2'd0,
        OP_COMMAND    = 2'd1,
        OP_ARM_TOGGLE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        REG_BISTABLE     = 2'd0,
        REG_PULSE_LEN    = 2'd1,
        REG_CHECK_PERIOD = 2'd2,
        REG_RETRY_LIMIT  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic        bistable_mode;
        logic [15:0] pulse_length_ms;
        logic [15:0] check_period_ms;
        logic [7:0]  retry_limit;
    } cfg_t;

    typedef struct packed {
        logic       theoretical_closed;
        logic [7:0] retry_count;
        logic       fault_flag;
        logic       close_line;
        logic       open_line;
    } flags_t;

    typedef struct packed {
        logic [7:0] retries_left;
        logic       fault;
        logic       commanded_closed;
        logic       drive_open;
        logic       drive_close;
    } result_t;

endpackage

`default_nettype wire

>>> sv/rdfc_step.sv
// ---------------------------------------------------------------------------
// Relay driver item step
// Next-state and result logic for one poll, command or toggle-arm item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdfc_step #(
    parameter int TIME_BITS = rdfc_pkg::TIME_BITS_DEFAULT
) (
    input  rdfc_pkg::cfg_t    cfg,
    input  rdfc_pkg::flags_t  flags_cur,
    input  logic [TIME_BITS-1:0] check_dl_cur,
    input  logic [TIME_BITS-1:0] toggle_dl_cur,
    input  logic [TIME_BITS-1:0] pulse_dl_cur,
    input  logic [1:0]        opcode,
    input  logic [31:0]       now_ms,
    input  logic              close_request,
    input  logic [31:0]       timeout_ms,
    input  logic              feedback_closed,
    output rdfc_pkg::flags_t  flags_nxt,
    output logic [TIME_BITS-1:0] check_dl_nxt,
    output logic [TIME_BITS-1:0] toggle_dl_nxt,
    output logic [TIME_BITS-1:0] pulse_dl_nxt,
    output rdfc_pkg::result_t result
);

    localparam logic [TIME_BITS-1:0] DISARMED = {TIME_BITS{1'b1}};

    typedef struct packed {
        rdfc_pkg::flags_t     fl;
        logic [TIME_BITS-1:0] check_dl;
        logic [TIME_BITS-1:0] toggle_dl;
        logic [TIME_BITS-1:0] pulse_dl;
    } st_t;

    function automatic st_t do_command(st_t s, logic want, logic [TIME_BITS-1:0] now,
                                       rdfc_pkg::cfg_t c);
        st_t r;
        r = s;
        if (c.bistable_mode) begin
            if (want) begin
                r.fl.close_line = 1'b1;
            end else begin
                r.fl.open_line = 1'b1;
            end
            r.pulse_dl = now + TIME_BITS'(c.pulse_length_ms);
        end else begin
            r.fl.close_line = want;
        end
        r.fl.theoretical_closed = want;
        r.check_dl = now + TIME_BITS'(rdfc_pkg::FORCED_CHECK_MS);
        return r;
    endfunction

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] timeout_t;
    st_t                  st;

    assign now_t     = TIME_BITS'(now_ms);
    assign timeout_t = TIME_BITS'(timeout_ms);

    always_comb begin
        st.fl        = flags_cur;
        st.check_dl  = check_dl_cur;
        st.toggle_dl = toggle_dl_cur;
        st.pulse_dl  = pulse_dl_cur;
        case (rdfc_pkg::opcode_t'(opcode))
            rdfc_pkg::OP_POLL: begin
                if (cfg.bistable_mode && (now_t > st.pulse_dl)) begin
                    st.pulse_dl      = DISARMED;
                    st.fl.close_line = 1'b0;
                    st.fl.open_line  = 1'b0;
                end
                if (now_t > st.toggle_dl) begin
                    st.toggle_dl = DISARMED;
                    st = do_command(st, !st.fl.theoretical_closed, now_t, cfg);
                end
                if (now_t > st.check_dl) begin
                    if (feedback_closed != st.fl.theoretical_closed) begin
                        st = do_command(st, st.fl.theoretical_closed, now_t, cfg);
                        if (st.fl.retry_count != 8'd0) begin
                            st.fl.retry_count = st.fl.retry_count - 8'd1;
                        end
                        if (st.fl.retry_count == 8'd0) begin
                            st.fl.fault_flag = 1'b1;
                        end
                    end else begin
                        st.fl.fault_flag  = 1'b0;
                        st.fl.retry_count = cfg.retry_limit;
                    end
                    st.check_dl = now_t + TIME_BITS'(cfg.check_period_ms);
                end
            end
            rdfc_pkg::OP_COMMAND: begin
                st = do_command(st, close_request, now_t, cfg);
            end
            rdfc_pkg::OP_ARM_TOGGLE: begin
                st.toggle_dl = now_t + timeout_t;
            end
            default: begin
            end
        endcase
    end

    assign flags_nxt     = st.fl;
    assign check_dl_nxt  = st.check_dl;
    assign toggle_dl_nxt = st.toggle_dl;
    assign pulse_dl_nxt  = st.pulse_dl;

    assign result.drive_close      = st.fl.close_line;
    assign result.drive_open       = cfg.bistable_mode & st.fl.open_line;
    assign result.commanded_closed = st.fl.theoretical_closed;
    assign result.fault            = st.fl.fault_flag;
    assign result.retries_left     = st.fl.retry_count;

endmodule

`default_nettype wire

>>> sv/relay_driver_with_feedback_check_top.sv
// ---------------------------------------------------------------------------
// Relay driver with feedback check
// Drives a monostable or bistable relay coil and checks its feedback contact.
// ---------------------------------------------------------------------------
// Channel   Ports        Contents
// input     s_tdata      now_ms, close_request, timeout_ms, feedback_closed
//           s_tuser      opcode
// result    m_tdata      drive_close, drive_open, commanded_closed, fault,
//                        retries_left
// config    cfg_*        one register write per cycle, no read-back
//
// An accepted item is held in the input register and passes through the step
// logic into the result register once the result side can take it, and its
// result is offered from there.
// A new item is accepted every cycle while the result side keeps up.
// A stalled result holds the input register, and then the input side stalls.
// Reset is synchronous and leaves the relay commanded open at time zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module relay_driver_with_feedback_check_top #(
    parameter int TIME_BITS = rdfc_pkg::TIME_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // now_ms[31:0], close_request[32], timeout_ms[64:33], feedback_closed[65]
    input  logic [rdfc_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode[1:0]
    input  logic [rdfc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // drive_close[0], drive_open[1], commanded_closed[2], fault[3],
    // retries_left[11:4]
    output logic [rdfc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [rdfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rdfc_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

    rdfc_pkg::cfg_t       cfg_reg;
    rdfc_pkg::flags_t     flags_reg;
    rdfc_pkg::flags_t     flags_next;
    logic [TIME_BITS-1:0] check_dl_reg;
    logic [TIME_BITS-1:0] check_dl_next;
    logic [TIME_BITS-1:0] toggle_dl_reg;
    logic [TIME_BITS-1:0] toggle_dl_next;
    logic [TIME_BITS-1:0] pulse_dl_reg;
    logic [TIME_BITS-1:0] pulse_dl_next;

    logic                 in_valid_reg;
    logic [1:0]           in_opcode_reg;
    logic [31:0]          in_now_reg;
    logic                 in_close_reg;
    logic [31:0]          in_timeout_reg;
    logic                 in_fb_reg;

    logic                 out_valid_reg;
    rdfc_pkg::result_t    out_res_reg;
    rdfc_pkg::result_t    res_next;

    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bistable_mode   <= rdfc_pkg::RST_BISTABLE;
            cfg_reg.pulse_length_ms <= rdfc_pkg::RST_PULSE_LEN;
            cfg_reg.check_period_ms <= rdfc_pkg::RST_CHECK_PERIOD;
            cfg_reg.retry_limit     <= rdfc_pkg::RST_RETRY_LIMIT;
        end else if (cfg_we) begin
            case (rdfc_pkg::reg_idx_t'(cfg_index))
                rdfc_pkg::REG_BISTABLE:     cfg_reg.bistable_mode   <= cfg_wdata[0];
                rdfc_pkg::REG_PULSE_LEN:    cfg_reg.pulse_length_ms <= cfg_wdata;
                rdfc_pkg::REG_CHECK_PERIOD: cfg_reg.check_period_ms <= cfg_wdata;
                rdfc_pkg::REG_RETRY_LIMIT:  cfg_reg.retry_limit     <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_opcode_reg  <= s_tuser[1:0];
            in_now_reg     <= s_tdata[31:0];
            in_close_reg   <= s_tdata[32];
            in_timeout_reg <= s_tdata[64:33];
            in_fb_reg      <= s_tdata[65];
        end
    end

    rdfc_step #(
        .TIME_BITS(TIME_BITS)
    ) u_step (
        .cfg            (cfg_reg),
        .flags_cur      (flags_reg),
        .check_dl_cur   (check_dl_reg),
        .toggle_dl_cur  (toggle_dl_reg),
        .pulse_dl_cur   (pulse_dl_reg),
        .opcode         (in_opcode_reg),
        .now_ms         (in_now_reg),
        .close_request  (in_close_reg),
        .timeout_ms     (in_timeout_reg),
        .feedback_closed(in_fb_reg),
        .flags_nxt      (flags_next),
        .check_dl_nxt   (check_dl_next),
        .toggle_dl_nxt  (toggle_dl_next),
        .pulse_dl_nxt   (pulse_dl_next),
        .result         (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg.theoretical_closed <= 1'b0;
            flags_reg.retry_count        <= rdfc_pkg::RST_RETRY_LIMIT;
            flags_reg.fault_flag         <= 1'b0;
            flags_reg.close_line         <= 1'b0;
            flags_reg.open_line          <= rdfc_pkg::RST_BISTABLE;
            check_dl_reg                 <= TIME_BITS'(rdfc_pkg::FORCED_CHECK_MS);
            toggle_dl_reg                <= {TIME_BITS{1'b1}};
            pulse_dl_reg                 <= '0;
        end else if (advance) begin
            flags_reg     <= flags_next;
            check_dl_reg  <= check_dl_next;
            toggle_dl_reg <= toggle_dl_next;
            pulse_dl_reg  <= pulse_dl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.retries_left, out_res_reg.fault,
                       out_res_reg.commanded_closed, out_res_reg.drive_open,
                       out_res_reg.drive_close};

endmodule

`default_nettype wire

>>> sv/rdfc_chk.sv
// ---------------------------------------------------------------------------
// Relay driver port checker
// Checks handshake and result consistency seen on the top-level ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "relay_driver_with_feedback_check_top_assert.svh"

module rdfc_chk (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tready,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [rdfc_pkg::M_TDATA_W-1:0] m_tdata
);

    logic       out_stall;
    logic       out_fault;
    logic [7:0] out_retries;

    assign out_stall   = m_tvalid && !m_tready;
    assign out_fault   = m_tvalid && m_tdata[3];
    assign out_retries = m_tdata[11:4];

    // A result that is not taken stays valid and unchanged.
    `RDFC_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "result not held")

    // The input side never stalls while the result side is ready.
    `RDFC_ASSERT_SAME(a_no_stall, m_tready, s_tready, "input stalled with result side ready")

    // A fault is only declared once the retries are used up.
    `RDFC_ASSERT_SAME(a_fault_retries, out_fault, out_retries == 8'd0, "fault with retries left")

    // No result is offered in the cycle after reset.
    `RDFC_ASSERT_RST_NEXT(a_reset_empty, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind relay_driver_with_feedback_check_top rdfc_chk u_rdfc_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire

>>> tb/relay_coil_checker.sv
// ---------------------------------------------------------------------------
// Relay driver result checker
// Watches the input, result and register-write ports of the relay driver.
// It keeps its own copy of the relay state and settings, works out the
// result that each accepted item must produce, and compares every accepted
// result, field by field, with the oldest one still waiting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module relay_coil_checker
    import rdfc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0]   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DAT_W-1:0]   cfg_wdata,
    output int                     fail_count,
    output int                     pending
);

    cfg_t        relay_cfg;
    logic        cmd_closed;
    logic [7:0]  retries;
    logic        fault_q;
    logic [31:0] check_dl;
    logic [31:0] toggle_dl;
    logic [31:0] pulse_dl;
    logic        close_q;
    logic        open_q;
    result_t     coil_results_due[$];

    function void command_coil(logic want_closed, logic [31:0] now);
        if (relay_cfg.bistable_mode) begin
            if (want_closed) begin
                close_q = 1'b1;
            end else begin
                open_q = 1'b1;
            end
            pulse_dl = now + {16'd0, relay_cfg.pulse_length_ms};
        end else begin
            close_q = want_closed;
        end
        cmd_closed = want_closed;
        check_dl   = now + 32'(FORCED_CHECK_MS);
    endfunction

    function void poll_coil(logic [31:0] now, logic feedback);
        if (relay_cfg.bistable_mode && now > pulse_dl) begin
            pulse_dl = '1;
            close_q  = 1'b0;
            open_q   = 1'b0;
        end
        if (now > toggle_dl) begin
            toggle_dl = '1;
            command_coil(!cmd_closed, now);
        end
        if (now > check_dl) begin
            if (feedback != cmd_closed) begin
                command_coil(cmd_closed, now);
                if (retries != 8'd0) begin
                    retries = retries - 8'd1;
                end
                if (retries == 8'd0) begin
                    fault_q = 1'b1;
                end
            end else begin
                fault_q = 1'b0;
                retries = relay_cfg.retry_limit;
            end
            check_dl = now + {16'd0, relay_cfg.check_period_ms};
        end
    endfunction

    always @(posedge aclk) begin
        result_t     seen;
        result_t     due;
        logic [31:0] now_ms;
        logic [31:0] timeout_ms;
        logic        close_req;
        logic        feedback;
        if (!aresetn) begin
            relay_cfg.bistable_mode   = RST_BISTABLE;
            relay_cfg.pulse_length_ms = RST_PULSE_LEN;
            relay_cfg.check_period_ms = RST_CHECK_PERIOD;
            relay_cfg.retry_limit     = RST_RETRY_LIMIT;
            cmd_closed = 1'b0;
            retries    = RST_RETRY_LIMIT;
            fault_q    = 1'b0;
            toggle_dl  = '1;
            close_q    = 1'b0;
            open_q     = 1'b0;
            pulse_dl   = '0;
            command_coil(1'b0, 32'd0);
            coil_results_due.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = result_t'(m_tdata[11:0]);
                if (coil_results_due.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: result with none expected: close=%0b open=%0b cmd=%0b fault=%0b retries=%0d",
                                 $realtime, seen.drive_close, seen.drive_open,
                                 seen.commanded_closed, seen.fault, seen.retries_left);
                    end
                    fail_count++;
                end else begin
                    due = coil_results_due.pop_front();
                    if (seen.drive_close !== due.drive_close ||
                        seen.drive_open !== due.drive_open ||
                        seen.commanded_closed !== due.commanded_closed ||
                        seen.fault !== due.fault ||
                        seen.retries_left !== due.retries_left) begin
                        if (fail_count < 10) begin
                            $display("%0t: mismatch: expected close=%0b open=%0b cmd=%0b fault=%0b retries=%0d",
                                     $realtime, due.drive_close, due.drive_open,
                                     due.commanded_closed, due.fault, due.retries_left);
                            $display("%0t:           got close=%0b open=%0b cmd=%0b fault=%0b retries=%0d",
                                     $realtime, seen.drive_close, seen.drive_open,
                                     seen.commanded_closed, seen.fault, seen.retries_left);
                        end
                        fail_count++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_BISTABLE:     relay_cfg.bistable_mode   = cfg_wdata[0];
                    REG_PULSE_LEN:    relay_cfg.pulse_length_ms = cfg_wdata;
                    REG_CHECK_PERIOD: relay_cfg.check_period_ms = cfg_wdata;
                    REG_RETRY_LIMIT:  relay_cfg.retry_limit     = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                now_ms     = s_tdata[31:0];
                close_req  = s_tdata[32];
                timeout_ms = s_tdata[64:33];
                feedback   = s_tdata[65];
                case (s_tuser)
                    OP_POLL:       poll_coil(now_ms, feedback);
                    OP_COMMAND:    command_coil(close_req, now_ms);
                    OP_ARM_TOGGLE: toggle_dl = now_ms + timeout_ms;
                    default: ;
                endcase
                due.drive_close      = close_q;
                due.drive_open       = relay_cfg.bistable_mode & open_q;
                due.commanded_closed = cmd_closed;
                due.fault            = fault_q;
                due.retries_left     = retries;
                coil_results_due.push_back(due);
            end
        end
        pending = coil_results_due.size();
    end

endmodule

>>> tb/tb_relay_driver_with_feedback_check_top.sv
// ---------------------------------------------------------------------------
// Relay driver testbench
// Runs a short directed sequence in monostable and bistable mode, then
// random polls, commands and toggle timeouts with a running millisecond time
// under several register settings. Input items come in bursts with gaps and
// the result side stalls on its own pattern; a separate checker compares
// every result against its own model of the relay.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_relay_driver_with_feedback_check_top;
    import rdfc_pkg::*;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         ITEMS_PER_PHASE = 210;

    typedef enum int {RX_FREE, RX_RANDOM, RX_BURSTY} rx_pattern_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_wdata = '0;

    int          fail_count;
    int          pending;
    logic [31:0] clock_ms    = '0;
    logic        fb_level    = 1'b0;
    int          burst_left  = 0;
    int          cur_check   = 5000;
    rx_pattern_t rx_mode     = RX_FREE;
    int          rx_left     = 0;
    int          rx_stall    = 0;

    always #6 aclk = ~aclk;

    relay_driver_with_feedback_check_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    relay_coil_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_pattern_t'($urandom_range(0, 2));
                rx_left = $urandom_range(50, 300);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE:   m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (rx_stall > 0) begin
                        m_tready <= 1'b0;
                        rx_stall--;
                    end else begin
                        m_tready <= 1'b1;
                        if ($urandom_range(0, 5) == 0) begin
                            rx_stall = $urandom_range(1, 8);
                        end
                    end
                end
            endcase
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [15:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_relay_config(logic bistable, logic [15:0] pulse_len,
                                    logic [15:0] check_period, logic [7:0] retry_limit);
        write_reg(REG_BISTABLE, {15'd0, bistable});
        write_reg(REG_PULSE_LEN, pulse_len);
        write_reg(REG_CHECK_PERIOD, check_period);
        write_reg(REG_RETRY_LIMIT, {8'd0, retry_limit});
        cur_check = check_period;
    endtask

    task automatic send_item(logic [1:0] op, logic [31:0] now, logic close_req,
                             logic [31:0] timeout, logic feedback);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, feedback, timeout, close_req, now};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic pause_sender(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic random_item(output logic [1:0] op);
        int          sel;
        int          span;
        logic [31:0] timeout;
        if (burst_left == 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            op = OP_POLL;
        end else if (sel < 77) begin
            op = OP_COMMAND;
        end else if (sel < 95) begin
            op = OP_ARM_TOGGLE;
        end else begin
            op = OP_UNUSED;
        end
        span = (cur_check > FORCED_CHECK_MS) ? cur_check : FORCED_CHECK_MS;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            clock_ms = clock_ms + $urandom_range(0, span / 4 + 2);
        end else if (sel < 85) begin
            clock_ms = clock_ms + $urandom_range(0, span + 2);
        end else if (sel < 97) begin
            clock_ms = clock_ms + $urandom_range(0, 70000);
        end else if (sel < 99) begin
            clock_ms = $urandom;
        end else begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        end
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            timeout = $urandom_range(0, 2 * span);
        end else if (sel < 80) begin
            timeout = $urandom_range(0, 70000);
        end else if (sel < 90) begin
            timeout = $urandom;
        end else if (sel < 95) begin
            timeout = '0;
        end else begin
            timeout = '1;
        end
        if ($urandom_range(0, 7) == 0) begin
            fb_level = ~fb_level;
        end
        send_item(op, clock_ms, $urandom_range(0, 1), timeout, fb_level);
    endtask

    task automatic random_phase();
        int         counted;
        logic [1:0] op;
        counted = 0;
        while (counted < ITEMS_PER_PHASE) begin
            random_item(op);
            if (op != OP_UNUSED) begin
                counted++;
            end
            if ($urandom_range(0, 299) == 0) begin
                drain_results();
            end
        end
    endtask

    initial begin
        int waited;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Monostable mode at the reset settings.
        send_item(OP_POLL, 32'd0, 1'b0, 32'd0, 1'b0);
        send_item(OP_POLL, 32'd1000, 1'b0, 32'd0, 1'b1);
        send_item(OP_POLL, 32'd1001, 1'b0, 32'd0, 1'b1);
        send_item(OP_COMMAND, 32'd1002, 1'b1, 32'd0, 1'b1);
        send_item(OP_ARM_TOGGLE, 32'd1003, 1'b0, 32'd0, 1'b1);
        send_item(OP_POLL, 32'd1004, 1'b0, 32'd0, 1'b1);
        send_item(OP_POLL, 32'd2005, 1'b0, 32'd0, 1'b1);
        send_item(OP_POLL, 32'd7006, 1'b0, 32'd0, 1'b1);
        send_item(OP_POLL, 32'd12007, 1'b0, 32'd0, 1'b1);
        send_item(OP_POLL, 32'd17008, 1'b0, 32'd0, 1'b0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_ARM_TOGGLE, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0);
        send_item(OP_POLL, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0);
        send_item(OP_ARM_TOGGLE, 32'hFFFF_FF00, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_POLL, 32'hFFFF_FF00, 1'b0, 32'd0, 1'b1);
        send_item(OP_COMMAND, 32'hFFFF_FC17, 1'b0, 32'd0, 1'b1);
        send_item(OP_POLL, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b1);
        send_item(OP_COMMAND, 32'd100, 1'b1, 32'd0, 1'b1);
        drain_results();

        // Bistable mode with zero pulse length, check period and retry limit.
        set_relay_config(1'b1, 16'd0, 16'd0, 8'd0);
        send_item(OP_POLL, 32'd200, 1'b0, 32'd0, 1'b1);
        send_item(OP_COMMAND, 32'd300, 1'b1, 32'd0, 1'b1);
        send_item(OP_POLL, 32'd300, 1'b0, 32'd0, 1'b1);
        send_item(OP_COMMAND, 32'd301, 1'b0, 32'd0, 1'b0);
        send_item(OP_POLL, 32'd302, 1'b0, 32'd0, 1'b1);
        send_item(OP_POLL, 32'd1302, 1'b0, 32'd0, 1'b1);
        send_item(OP_POLL, 32'd1303, 1'b0, 32'd0, 1'b0);
        send_item(OP_POLL, 32'd1304, 1'b0, 32'd0, 1'b1);
        clock_ms = 32'd1304;
        random_phase();
        drain_results();

        set_relay_config(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
        random_phase();
        drain_results();

        set_relay_config(1'b0, 16'd1, 16'd1, 8'd1);
        random_phase();
        drain_results();

        set_relay_config(1'b1, 16'd20, 16'd300, 8'd2);
        random_phase();

        repeat (2) begin
            drain_results();
            set_relay_config($urandom_range(0, 1), $urandom_range(0, 400),
                             $urandom_range(0, 3000), $urandom_range(0, 6));
            random_phase();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
